// ----- hw/rtl/euler_to_quaternion_top_assert.svh -----
// Assertion macros used by the checker file e2q_checker.sv.
`ifndef EULER_TO_QUATERNION_TOP_ASSERT_SVH
`define EULER_TO_QUATERNION_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define E2Q_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("e2q assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define E2Q_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("e2q assertion failed");

`endif

// ----- hw/rtl/e2q_pkg.sv -----
package e2q_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS = 15;
  localparam int OUT_W = FRAC_BITS + 1;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W = 33;
  localparam int TRIG_W = 32;
  localparam int Q_BITS = 30;
  localparam int TURN_BITS = 31;

  localparam int PRODUCT_STAGES = 5;
  localparam int LATENCY = CORDIC_STEPS + PRODUCT_STAGES;

  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [63:0] wide_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [OUT_W-1:0] quat_t;

endpackage

// ----- hw/rtl/e2q_cordic.sv -----
module e2q_cordic
  import e2q_pkg::*;
(
  input  logic   clk_i,
  input  logic   adv_i,
  input  angle_t angle_i,
  output trig_t  cos_o,
  output trig_t  sin_o
);

  typedef logic signed [CORDIC_W-1:0] cw_t;

  cw_t x_q [CORDIC_STEPS];
  cw_t y_q [CORDIC_STEPS];
  cw_t z_q [CORDIC_STEPS-1];

  cw_t z_init;

  // halve the angle: scale to 2^-32 turn units
  assign z_init = {{(CORDIC_W - TURN_BITS){angle_i[ANGLE_BITS-1]}}, angle_i,
                   {(TURN_BITS - ANGLE_BITS){1'b0}}};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cw_t x_in;
    cw_t y_in;
    cw_t z_in;
    cw_t x_d;
    cw_t y_d;

    if (i == 0) begin : g_first
      assign x_in = cw_t'(CORDIC_GAIN);
      assign y_in = '0;
      assign z_in = z_init;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    always_comb begin
      if (!z_in[CORDIC_W-1]) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_z
      localparam cw_t TURN = cw_t'(ATAN_TURNS[i]);
      cw_t z_d;

      assign z_d = z_in[CORDIC_W-1] ? (z_in + TURN) : (z_in - TURN);

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          z_q[i] <= z_d;
        end
      end
    end
  end

  assign cos_o = x_q[CORDIC_STEPS-1][TRIG_W-1:0];
  assign sin_o = y_q[CORDIC_STEPS-1][TRIG_W-1:0];

endmodule

// ----- hw/rtl/e2q_combine.sv -----
module e2q_combine
  import e2q_pkg::*;
(
  input  logic  clk_i,
  input  logic  adv_i,
  input  trig_t cr_i,
  input  trig_t sr_i,
  input  trig_t cp_i,
  input  trig_t sp_i,
  input  trig_t cy_i,
  input  trig_t sy_i,
  output quat_t quat_w_o,
  output quat_t quat_x_o,
  output quat_t quat_y_o,
  output quat_t quat_z_o
);

  localparam wide_t PAIR_HALF = 64'sd1 <<< (Q_BITS - 1);
  localparam int OUT_SH = 2 * Q_BITS - FRAC_BITS;
  localparam wide_t OUT_HALF = 64'sd1 <<< (OUT_SH - 1);
  localparam wide_t OUT_MAX = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam wide_t OUT_MIN = -(64'sd1 <<< FRAC_BITS);

  function automatic trig_t round_pair(input wide_t v);
    wide_t r;
    r = (v + PAIR_HALF) >>> Q_BITS;
    return r[TRIG_W-1:0];
  endfunction

  function automatic quat_t round_sat(input wide_t v);
    wide_t r;
    wide_t res;
    r = (v + OUT_HALF) >>> OUT_SH;
    res = r;
    if (r > OUT_MAX) begin
      res = OUT_MAX;
    end
    if (r < OUT_MIN) begin
      res = OUT_MIN;
    end
    return res[OUT_W-1:0];
  endfunction

  wide_t cc_q, ss_q, sc_q, cs_q;
  trig_t cya_q, sya_q;
  trig_t ccr_q, ssr_q, scr_q, csr_q;
  trig_t cyb_q, syb_q;
  wide_t w1_q, w2_q, x1_q, x2_q, y1_q, y2_q, z1_q, z2_q;
  wide_t sum_w_q, sum_x_q, sum_y_q, sum_z_q;
  quat_t quat_w_q, quat_x_q, quat_y_q, quat_z_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // roll and pitch pair products
      cc_q  <= wide_t'(cr_i) * wide_t'(cp_i);
      ss_q  <= wide_t'(sr_i) * wide_t'(sp_i);
      sc_q  <= wide_t'(sr_i) * wide_t'(cp_i);
      cs_q  <= wide_t'(cr_i) * wide_t'(sp_i);
      cya_q <= cy_i;
      sya_q <= sy_i;
      // back to Q30
      ccr_q <= round_pair(cc_q);
      ssr_q <= round_pair(ss_q);
      scr_q <= round_pair(sc_q);
      csr_q <= round_pair(cs_q);
      cyb_q <= cya_q;
      syb_q <= sya_q;
      // yaw products
      w1_q  <= wide_t'(ccr_q) * wide_t'(cyb_q);
      w2_q  <= wide_t'(ssr_q) * wide_t'(syb_q);
      x1_q  <= wide_t'(scr_q) * wide_t'(cyb_q);
      x2_q  <= wide_t'(csr_q) * wide_t'(syb_q);
      y1_q  <= wide_t'(csr_q) * wide_t'(cyb_q);
      y2_q  <= wide_t'(scr_q) * wide_t'(syb_q);
      z1_q  <= wide_t'(ccr_q) * wide_t'(syb_q);
      z2_q  <= wide_t'(ssr_q) * wide_t'(cyb_q);
      // combine terms
      sum_w_q <= w1_q + w2_q;
      sum_x_q <= x1_q - x2_q;
      sum_y_q <= y1_q + y2_q;
      sum_z_q <= z1_q - z2_q;
      // round and saturate
      quat_w_q <= round_sat(sum_w_q);
      quat_x_q <= round_sat(sum_x_q);
      quat_y_q <= round_sat(sum_y_q);
      quat_z_q <= round_sat(sum_z_q);
    end
  end

  assign quat_w_o = quat_w_q;
  assign quat_x_o = quat_x_q;
  assign quat_y_o = quat_y_q;
  assign quat_z_o = quat_z_q;

endmodule

// ----- hw/rtl/euler_to_quaternion_top.sv -----
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   roll_angle_i, pitch_angle_i, yaw_angle_i
// out      output     out_valid_o / out_ready_i quat_w_o, quat_x_o, quat_y_o, quat_z_o
//
// One request per cycle while the output is not stalled; 24 CORDIC stages per angle, then
// five product, rounding and saturation stages.
// Reset clears the valid bits only; payload registers carry no reset.
// A result waiting at the output with out_ready_i low holds the whole pipeline,
// and in_ready_o falls in the same cycle.
module euler_to_quaternion_top
  import e2q_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  angle_t roll_angle_i,
  input  angle_t pitch_angle_i,
  input  angle_t yaw_angle_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output quat_t  quat_w_o,
  output quat_t  quat_x_o,
  output quat_t  quat_y_o,
  output quat_t  quat_z_o
);

  logic [LATENCY-1:0] valid_q;
  logic               adv;

  trig_t cr, sr, cp, sp, cy, sy;

  assign adv = !valid_q[LATENCY-1] || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[LATENCY-2:0], in_valid_i};
    end
  end

  e2q_cordic u_roll (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .angle_i (roll_angle_i),
    .cos_o   (cr),
    .sin_o   (sr)
  );

  e2q_cordic u_pitch (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .angle_i (pitch_angle_i),
    .cos_o   (cp),
    .sin_o   (sp)
  );

  e2q_cordic u_yaw (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .angle_i (yaw_angle_i),
    .cos_o   (cy),
    .sin_o   (sy)
  );

  e2q_combine u_combine (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .cr_i     (cr),
    .sr_i     (sr),
    .cp_i     (cp),
    .sp_i     (sp),
    .cy_i     (cy),
    .sy_i     (sy),
    .quat_w_o (quat_w_o),
    .quat_x_o (quat_x_o),
    .quat_y_o (quat_y_o),
    .quat_z_o (quat_z_o)
  );

  assign in_ready_o  = adv;
  assign out_valid_o = valid_q[LATENCY-1];

endmodule

// ----- hw/rtl/e2q_checker.sv -----
`include "euler_to_quaternion_top_assert.svh"

module e2q_checker
  import e2q_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_ready_o,
  input logic   out_valid_o,
  input logic   out_ready_i,
  input quat_t  quat_w_o,
  input quat_t  quat_x_o,
  input quat_t  quat_y_o,
  input quat_t  quat_z_o
);

  logic out_stall;

  assign out_stall = out_valid_o && !out_ready_i;

  // drain side open: never refuse a request
  `E2Q_ASSERT_IMPL(a_ready_follows_out, out_ready_i, in_ready_o)

  // empty output stage: never refuse a request
  `E2Q_ASSERT_IMPL(a_ready_when_empty, !out_valid_o, in_ready_o)

  // stalled output holds valid
  `E2Q_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o)

  // stalled output holds its payload
  `E2Q_ASSERT_NEXT(a_out_stable, out_stall, $stable({quat_w_o, quat_x_o, quat_y_o, quat_z_o}))

endmodule

bind euler_to_quaternion_top e2q_checker u_e2q_checker (.*);
